// ===== hdl/fsalu_pkg.sv =====
// ----------------------------------------------------------------------------
// fsalu_pkg
// Shared types and constants of the flag-setting ALU: opcodes, the decoded
// micro-operation that travels from the front end to the execute stage,
// and the sizes of the fields.
// ----------------------------------------------------------------------------
package fsalu_pkg;

   localparam int DATA_W      = 32;
   localparam int OPCODE_W    = 4;
   localparam int REG_IDX_W   = 3;
   localparam int SHIFT_W     = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DATA_W-1:0] SIGN_MASK = 32'h8000_0000;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_AND = 4'd2,
      OP_OR  = 4'd3,
      OP_XOR = 4'd4,
      OP_LSR = 4'd5,
      OP_LSL = 4'd6,
      OP_MOV = 4'd7,
      OP_CMP = 4'd8,
      OP_TST = 4'd9
   } op_type;

   typedef enum logic [3:0] {
      FN_NONE = 4'd0,
      FN_ADD  = 4'd1,
      FN_SUB  = 4'd2,
      FN_AND  = 4'd3,
      FN_OR   = 4'd4,
      FN_XOR  = 4'd5,
      FN_LSR  = 4'd6,
      FN_LSL  = 4'd7,
      FN_MOV  = 4'd8
   } fn_type;

   typedef struct packed {
      fn_type                 fn;
      logic                   writes;
      logic                   sets_nz;
      logic [REG_IDX_W-1:0]   src_a;
      logic                   src_a_ok;
      logic [REG_IDX_W-1:0]   src_b;
      logic                   src_b_ok;
      logic [REG_IDX_W-1:0]   dest;
      logic                   dest_ok;
      logic [SHIFT_W-1:0]     shift;
      logic [DATA_W-1:0]      imm;
   } uop_type;

endpackage

// ===== hdl/fsalu_req_if.sv =====
// ----------------------------------------------------------------------------
// fsalu_req_if
// Instruction channel: valid/ready handshake with the instruction fields.
// ----------------------------------------------------------------------------
interface fsalu_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  opcode;
   logic [2:0]  dest_reg;
   logic [2:0]  src_a_reg;
   logic [2:0]  src_b_reg;
   logic [4:0]  shift_amount;
   logic [31:0] immediate;

   modport source (
      output valid, opcode, dest_reg, src_a_reg, src_b_reg, shift_amount, immediate,
      input  ready
   );

   modport sink (
      input  valid, opcode, dest_reg, src_a_reg, src_b_reg, shift_amount, immediate,
      output ready
   );
endinterface

// ===== hdl/fsalu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fsalu_rsp_if
// Result channel: valid/ready handshake with the result value and flags.
// ----------------------------------------------------------------------------
interface fsalu_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_value;
   logic        flag_n;
   logic        flag_z;
   logic        flag_c;
   logic        flag_v;
   logic        reg_written;

   modport source (
      output valid, result_value, flag_n, flag_z, flag_c, flag_v, reg_written,
      input  ready
   );

   modport sink (
      input  valid, result_value, flag_n, flag_z, flag_c, flag_v, reg_written,
      output ready
   );
endinterface

// ===== hdl/fsalu_ram.sv =====
// ----------------------------------------------------------------------------
// fsalu_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module fsalu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== hdl/fsalu_front.sv =====
// ----------------------------------------------------------------------------
// fsalu_front
// Front end: accepts instruction beats, decodes the opcode into an
// execute function and checks register indexes against the file size.
// ----------------------------------------------------------------------------
module fsalu_front #(
   parameter int NUM_REGS = 8
) (
   fsalu_req_if.sink           req,
   input  logic                queue_full,
   output logic                push,
   output fsalu_pkg::uop_type  uop
);
   import fsalu_pkg::*;

   localparam logic [REG_IDX_W+1:0] REG_LIMIT = (REG_IDX_W + 2)'(NUM_REGS);

   function automatic logic idx_ok(input logic [REG_IDX_W-1:0] idx);
      return {2'b00, idx} < REG_LIMIT;
   endfunction

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   always_comb begin
      uop          = '0;
      uop.src_a    = req.src_a_reg;
      uop.src_a_ok = idx_ok(req.src_a_reg);
      uop.src_b    = req.src_b_reg;
      uop.src_b_ok = idx_ok(req.src_b_reg);
      uop.dest     = req.dest_reg;
      uop.dest_ok  = idx_ok(req.dest_reg);
      uop.shift    = req.shift_amount;
      uop.imm      = req.immediate;
      unique case (op_type'(req.opcode))
         OP_ADD: begin uop.fn = FN_ADD; uop.writes = 1'b1; uop.sets_nz = 1'b1; end
         OP_SUB: begin uop.fn = FN_SUB; uop.writes = 1'b1; uop.sets_nz = 1'b1; end
         OP_AND: begin uop.fn = FN_AND; uop.writes = 1'b1; uop.sets_nz = 1'b1; end
         OP_OR:  begin uop.fn = FN_OR;  uop.writes = 1'b1; uop.sets_nz = 1'b1; end
         OP_XOR: begin uop.fn = FN_XOR; uop.writes = 1'b1; uop.sets_nz = 1'b1; end
         OP_LSR: begin uop.fn = FN_LSR; uop.writes = 1'b1; uop.sets_nz = 1'b1; end
         OP_LSL: begin uop.fn = FN_LSL; uop.writes = 1'b1; uop.sets_nz = 1'b1; end
         OP_MOV: begin uop.fn = FN_MOV; uop.writes = 1'b1; uop.sets_nz = 1'b0; end
         OP_CMP: begin uop.fn = FN_SUB; uop.writes = 1'b0; uop.sets_nz = 1'b1; end
         OP_TST: begin uop.fn = FN_AND; uop.writes = 1'b0; uop.sets_nz = 1'b1; end
         default: begin uop.fn = FN_NONE; uop.writes = 1'b0; uop.sets_nz = 1'b0; end
      endcase
   end

endmodule

// ===== hdl/fsalu_queue.sv =====
// ----------------------------------------------------------------------------
// fsalu_queue
// Short FIFO of decoded instructions between the front end and the
// execute stage.
// ----------------------------------------------------------------------------
module fsalu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fsalu_pkg::uop_type  push_uop,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output fsalu_pkg::uop_type  head_uop
);
   import fsalu_pkg::*;

   localparam logic [QUEUE_CNT_W-1:0] FULL_COUNT = QUEUE_CNT_W'(QUEUE_DEPTH);
   localparam logic [QUEUE_PTR_W-1:0] LAST_PTR   = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

   uop_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_uop   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_uop;
      end
   end

endmodule

// ===== hdl/fsalu_back.sv =====
// ----------------------------------------------------------------------------
// fsalu_back
// Execute stage: reads the register file, computes the result and the
// NZCV flags, writes back, and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module fsalu_back #(
   parameter int NUM_REGS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  fsalu_pkg::uop_type  head_uop,
   output logic                pop,
   fsalu_rsp_if.source         rsp
);
   import fsalu_pkg::*;

   localparam int RF_DEPTH = (NUM_REGS < (1 << REG_IDX_W)) ? NUM_REGS : (1 << REG_IDX_W);
   localparam int RF_AW    = $clog2(RF_DEPTH);

   logic                 ex_valid_ff, ex_valid_in;
   uop_type              ex_uop_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_value_ff;
   logic                 rsp_n_ff, rsp_z_ff, rsp_c_ff, rsp_v_ff, rsp_w_ff;
   logic                 fwd_valid_ff;
   logic [RF_AW-1:0]     fwd_addr_ff;
   logic [DATA_W-1:0]    fwd_data_ff;
   logic [RF_DEPTH-1:0]  written_ff, written_in;

   logic                 retire;
   logic [RF_AW-1:0]     addr_a, addr_b, addr_d;
   logic [DATA_W-1:0]    ram_a, ram_b;
   logic [DATA_W-1:0]    opnd_a, opnd_b;
   logic [DATA_W-1:0]    adder_b;
   logic [DATA_W:0]      sum;
   logic [SHIFT_W-1:0]   lsr_idx, lsl_idx;
   logic [DATA_W-1:0]    res;
   logic                 res_c, res_v, res_n, res_z;
   logic                 wr_en;

   assign retire = ex_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign pop    = head_valid && (!ex_valid_ff || retire);

   assign addr_a = ex_uop_ff.src_a[RF_AW-1:0];
   assign addr_b = ex_uop_ff.src_b[RF_AW-1:0];
   assign addr_d = ex_uop_ff.dest[RF_AW-1:0];

   fsalu_ram #(
      .WIDTH (DATA_W),
      .DEPTH (RF_DEPTH)
   ) u_regfile (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (addr_d),
      .wr_data   (res),
      .rd_en     (pop),
      .rd_addr_a (head_uop.src_a[RF_AW-1:0]),
      .rd_addr_b (head_uop.src_b[RF_AW-1:0]),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   // The write of the previous instruction lands in the same cycle as this
   // instruction's read, so the last written word is forwarded.
   always_comb begin
      if (!ex_uop_ff.src_a_ok) begin
         opnd_a = '0;
      end else if (fwd_valid_ff && fwd_addr_ff == addr_a) begin
         opnd_a = fwd_data_ff;
      end else if (written_ff[addr_a]) begin
         opnd_a = ram_a;
      end else begin
         opnd_a = '0;
      end
      if (!ex_uop_ff.src_b_ok) begin
         opnd_b = '0;
      end else if (fwd_valid_ff && fwd_addr_ff == addr_b) begin
         opnd_b = fwd_data_ff;
      end else if (written_ff[addr_b]) begin
         opnd_b = ram_b;
      end else begin
         opnd_b = '0;
      end
   end

   assign adder_b = (ex_uop_ff.fn == FN_SUB) ? ~opnd_b : opnd_b;
   assign sum     = {1'b0, opnd_a} + {1'b0, adder_b} + (DATA_W + 1)'(ex_uop_ff.fn == FN_SUB);
   assign lsr_idx = ex_uop_ff.shift - 1'b1;
   assign lsl_idx = SHIFT_W'((SHIFT_W + 1)'(DATA_W) - {1'b0, ex_uop_ff.shift});

   always_comb begin
      res   = '0;
      res_c = 1'b0;
      res_v = 1'b0;
      unique case (ex_uop_ff.fn)
         FN_ADD: begin
            res   = sum[DATA_W-1:0];
            res_c = sum[DATA_W];
            res_v = |(~(opnd_a ^ opnd_b) & (opnd_a ^ sum[DATA_W-1:0]) & SIGN_MASK);
         end
         FN_SUB: begin
            res   = sum[DATA_W-1:0];
            res_c = sum[DATA_W];
            res_v = |((opnd_a ^ opnd_b) & (opnd_a ^ sum[DATA_W-1:0]) & SIGN_MASK);
         end
         FN_AND: res = opnd_a & opnd_b;
         FN_OR:  res = opnd_a | opnd_b;
         FN_XOR: res = opnd_a ^ opnd_b;
         FN_LSR: begin
            res   = opnd_a >> ex_uop_ff.shift;
            res_c = (ex_uop_ff.shift != '0) && opnd_a[lsr_idx];
         end
         FN_LSL: begin
            res   = opnd_a << ex_uop_ff.shift;
            res_c = (ex_uop_ff.shift != '0) && opnd_a[lsl_idx];
         end
         FN_MOV: res = ex_uop_ff.imm;
         default: res = '0;
      endcase
   end

   assign res_n = ex_uop_ff.sets_nz && |(res & SIGN_MASK);
   assign res_z = ex_uop_ff.sets_nz && (res == '0);
   assign wr_en = retire && ex_uop_ff.writes && ex_uop_ff.dest_ok;

   always_comb begin
      ex_valid_in = ex_valid_ff;
      if (pop) begin
         ex_valid_in = 1'b1;
      end else if (retire) begin
         ex_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (retire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      written_in = written_ff;
      if (wr_en) begin
         written_in[addr_d] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
         written_ff   <= '0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         written_ff   <= written_in;
         if (wr_en) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         ex_uop_ff <= head_uop;
      end
      if (wr_en) begin
         fwd_addr_ff <= addr_d;
         fwd_data_ff <= res;
      end
      if (retire) begin
         rsp_value_ff <= res;
         rsp_n_ff     <= res_n;
         rsp_z_ff     <= res_z;
         rsp_c_ff     <= res_c;
         rsp_v_ff     <= res_v;
         rsp_w_ff     <= wr_en;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_value = rsp_value_ff;
   assign rsp.flag_n       = rsp_n_ff;
   assign rsp.flag_z       = rsp_z_ff;
   assign rsp.flag_c       = rsp_c_ff;
   assign rsp.flag_v       = rsp_v_ff;
   assign rsp.reg_written  = rsp_w_ff;

endmodule

// ===== hdl/flag_setting_alu_with_register_file_core.sv =====
// A beat accepted into the queue is popped into the execute register and then offered
// as a result beat from the response register, taken when the result side is ready;
// throughput is one instruction per cycle while the result side is ready, set by the
// single execute stage and its two-read register file.
// Reset clears all control state and the register file reads as zero at once;
// there is no clearing sweep.
// ----------------------------------------------------------------------------
// flag_setting_alu_with_register_file_core
// ALU with NZCV flags over a small register file: a front end decodes each
// instruction beat into a short queue, and an execute stage reads operands,
// computes, writes back and returns one result beat per instruction.
// ----------------------------------------------------------------------------
module flag_setting_alu_with_register_file_core #(
   parameter int NUM_REGS = 8
) (
   input  logic          clock,
   input  logic          reset,
   fsalu_req_if.sink     req_chan,
   fsalu_rsp_if.source   rsp_chan
);
   import fsalu_pkg::*;

   logic    push;
   logic    queue_full;
   uop_type front_uop;
   logic    pop;
   logic    head_valid;
   uop_type head_uop;

   fsalu_front #(
      .NUM_REGS (NUM_REGS)
   ) u_front (
      .req        (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .uop        (front_uop)
   );

   fsalu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_uop   (front_uop),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_uop   (head_uop)
   );

   fsalu_back #(
      .NUM_REGS (NUM_REGS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_uop   (head_uop),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule

// ===== dv/flag_setting_alu_with_register_file_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flag_setting_alu_with_register_file_core_tb
// Drives instruction beats into the flag-setting ALU and checks every result
// beat against a cycle-free model of the register file and the NZCV flags.
// A directed opening covers the flag corners, all operations and undefined
// opcodes. Random instructions follow, with bursts of idling on both sides
// and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module flag_setting_alu_with_register_file_core_tb;
   import fsalu_pkg::*;

   localparam int NUM_REGS         = 8;
   localparam int RANDOM_ITEMS     = 1500;
   localparam int QUIET_FROM       = 1300;
   localparam int HOLD_AFTER_BEATS = 200;
   localparam int HOLD_CYCLES      = 300;
   localparam int DRAIN_CYCLES     = 16;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int REPORT_LIMIT     = 10;

   localparam logic [OPCODE_W-1:0] OP_UNDEF_FIRST = 4'd10;
   localparam logic [OPCODE_W-1:0] OP_UNDEF_LAST  = 4'd15;

   typedef struct packed {
      logic [OPCODE_W-1:0]  opcode;
      logic [REG_IDX_W-1:0] dest;
      logic [REG_IDX_W-1:0] src_a;
      logic [REG_IDX_W-1:0] src_b;
      logic [SHIFT_W-1:0]   shift;
      logic [DATA_W-1:0]    imm;
   } instr_t;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              n;
      logic              z;
      logic              c;
      logic              v;
      logic              written;
   } result_t;

   class alu_scoreboard;
      logic [DATA_W-1:0] regs [NUM_REGS];
      result_t           pending[$];
      int                mismatches;
      int                checked;
      int                undefined_seen;

      function new();
         foreach (regs[i]) regs[i] = '0;
         mismatches     = 0;
         checked        = 0;
         undefined_seen = 0;
      endfunction

      function result_t alu_result(instr_t ins);
         logic [DATA_W-1:0] a;
         logic [DATA_W-1:0] b;
         logic [DATA_W-1:0] r;
         logic [DATA_W:0]   sum;
         logic              c;
         logic              v;
         logic              writes;
         logic              sets_nz;
         result_t           res;
         a       = (ins.src_a < NUM_REGS) ? regs[ins.src_a] : '0;
         b       = (ins.src_b < NUM_REGS) ? regs[ins.src_b] : '0;
         r       = '0;
         c       = 1'b0;
         v       = 1'b0;
         writes  = 1'b1;
         sets_nz = 1'b1;
         case (ins.opcode)
            OP_ADD: begin
               sum = {1'b0, a} + {1'b0, b};
               r   = sum[DATA_W-1:0];
               c   = sum[DATA_W];
               v   = (a[31] == b[31]) && (r[31] != a[31]);
            end
            OP_SUB, OP_CMP: begin
               r      = a - b;
               c      = (a >= b);
               v      = (a[31] != b[31]) && (r[31] != a[31]);
               writes = (ins.opcode != OP_CMP);
            end
            OP_AND, OP_TST: begin
               r      = a & b;
               writes = (ins.opcode != OP_TST);
            end
            OP_OR:  r = a | b;
            OP_XOR: r = a ^ b;
            OP_LSR: begin
               r = a >> ins.shift;
               if (ins.shift != '0) c = a[ins.shift - 5'd1];
            end
            OP_LSL: begin
               r = a << ins.shift;
               if (ins.shift != '0) c = a[6'd32 - {1'b0, ins.shift}];
            end
            OP_MOV: begin
               r       = ins.imm;
               sets_nz = 1'b0;
            end
            default: begin
               writes  = 1'b0;
               sets_nz = 1'b0;
            end
         endcase
         res.value   = r;
         res.n       = sets_nz & r[31];
         res.z       = sets_nz & (r == '0);
         res.c       = c;
         res.v       = v;
         res.written = 1'b0;
         if (writes && ins.dest < NUM_REGS) begin
            regs[ins.dest] = r;
            res.written    = 1'b1;
         end
         return res;
      endfunction

      function void note_instr(instr_t ins);
         if (ins.opcode >= OP_UNDEF_FIRST) undefined_seen++;
         pending.push_back(alu_result(ins));
      endfunction

      function void check_result(result_t got);
         result_t want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result beat: value=%h nzcv=%b%b%b%b written=%b",
                        got.value, got.n, got.z, got.c, got.v, got.written);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.value !== want.value || got.n !== want.n || got.z !== want.z ||
             got.c !== want.c || got.v !== want.v || got.written !== want.written) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display({"result %0d mismatch: expected value=%h nzcv=%b%b%b%b written=%b,",
                         " got value=%h nzcv=%b%b%b%b written=%b"},
                        checked, want.value, want.n, want.z, want.c, want.v, want.written,
                        got.value, got.n, got.z, got.c, got.v, got.written);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   quiet = 1'b0;
   bit   hold_done = 1'b0;
   int   accepted_count = 0;
   int   cycle_count = 0;

   alu_scoreboard sb = new();

   fsalu_req_if req_if();
   fsalu_rsp_if rsp_if();

   flag_setting_alu_with_register_file_core #(
      .NUM_REGS (NUM_REGS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Input beats are noted before results are checked so that the order of
   // processes within one edge cannot matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            sb.note_instr(instr_t'{opcode: req_if.opcode, dest: req_if.dest_reg,
                                   src_a: req_if.src_a_reg, src_b: req_if.src_b_reg,
                                   shift: req_if.shift_amount, imm: req_if.immediate});
            accepted_count++;
         end
         if (rsp_if.valid && rsp_if.ready)
            sb.check_result(result_t'{value: rsp_if.result_value, n: rsp_if.flag_n,
                                      z: rsp_if.flag_z, c: rsp_if.flag_c,
                                      v: rsp_if.flag_v, written: rsp_if.reg_written});
      end
   end

   initial begin
      @(posedge clock);
      forever begin
         if (quiet) begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end else if (!hold_done && accepted_count >= HOLD_AFTER_BEATS) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   function automatic instr_t make_instr(logic [OPCODE_W-1:0] opcode,
                                         logic [REG_IDX_W-1:0] dest,
                                         logic [REG_IDX_W-1:0] src_a,
                                         logic [REG_IDX_W-1:0] src_b,
                                         logic [SHIFT_W-1:0] shift,
                                         logic [DATA_W-1:0] imm);
      return instr_t'{opcode: opcode, dest: dest, src_a: src_a, src_b: src_b,
                      shift: shift, imm: imm};
   endfunction

   function automatic instr_t random_instr();
      instr_t ins;
      int     pick;
      int     k;
      pick       = $urandom_range(0, 99);
      ins.dest   = REG_IDX_W'($urandom);
      ins.src_a  = REG_IDX_W'($urandom);
      ins.src_b  = REG_IDX_W'($urandom);
      ins.shift  = ($urandom_range(0, 7) == 0) ? '0 : SHIFT_W'($urandom);
      case ($urandom_range(0, 5))
         0: ins.imm = '0;
         1: ins.imm = '1;
         2: ins.imm = SIGN_MASK;
         3: ins.imm = ~SIGN_MASK;
         default: ins.imm = $urandom;
      endcase
      if (pick < 18) begin
         ins.opcode = OP_MOV;
      end else if (pick < 21) begin
         ins.opcode = OPCODE_W'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
      end else begin
         k = $urandom_range(0, 8);
         if (k == 7)      ins.opcode = OP_CMP;
         else if (k == 8) ins.opcode = OP_TST;
         else             ins.opcode = OPCODE_W'(k);
      end
      return ins;
   endfunction

   task automatic sender_gap();
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic send_instr(instr_t ins);
      sender_gap();
      req_if.valid        <= 1'b1;
      req_if.opcode       <= ins.opcode;
      req_if.dest_reg     <= ins.dest;
      req_if.src_a_reg    <= ins.src_a;
      req_if.src_b_reg    <= ins.src_b;
      req_if.shift_amount <= ins.shift;
      req_if.immediate    <= ins.imm;
      do @(posedge clock); while (!req_if.ready);
   endtask

   initial begin
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.opcode       <= '0;
      req_if.dest_reg     <= '0;
      req_if.src_a_reg    <= '0;
      req_if.src_b_reg    <= '0;
      req_if.shift_amount <= '0;
      req_if.immediate    <= '0;
      rsp_if.ready        <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_instr(make_instr(OP_MOV, 3'd0, 3'd0, 3'd0, 5'd0, 32'hFFFF_FFFF));
      send_instr(make_instr(OP_MOV, 3'd1, 3'd0, 3'd0, 5'd0, SIGN_MASK));
      send_instr(make_instr(OP_MOV, 3'd2, 3'd0, 3'd0, 5'd0, ~SIGN_MASK));
      send_instr(make_instr(OP_MOV, 3'd3, 3'd0, 3'd0, 5'd0, 32'd1));
      send_instr(make_instr(OP_MOV, 3'd4, 3'd7, 3'd7, 5'd31, 32'd0));
      send_instr(make_instr(OP_ADD, 3'd5, 3'd0, 3'd3, 5'd0, 32'd0));
      send_instr(make_instr(OP_ADD, 3'd6, 3'd2, 3'd3, 5'd0, 32'd0));
      send_instr(make_instr(OP_ADD, 3'd5, 3'd1, 3'd1, 5'd0, 32'd0));
      send_instr(make_instr(OP_SUB, 3'd6, 3'd4, 3'd3, 5'd0, 32'd0));
      send_instr(make_instr(OP_SUB, 3'd6, 3'd1, 3'd3, 5'd0, 32'd0));
      send_instr(make_instr(OP_SUB, 3'd7, 3'd0, 3'd0, 5'd0, 32'd0));
      send_instr(make_instr(OP_CMP, 3'd7, 3'd2, 3'd0, 5'd0, 32'd0));
      send_instr(make_instr(OP_CMP, 3'd3, 3'd1, 3'd2, 5'd0, 32'd0));
      send_instr(make_instr(OP_AND, 3'd5, 3'd0, 3'd1, 5'd0, 32'd0));
      send_instr(make_instr(OP_OR,  3'd6, 3'd2, 3'd1, 5'd0, 32'd0));
      send_instr(make_instr(OP_XOR, 3'd7, 3'd0, 3'd0, 5'd0, 32'd0));
      send_instr(make_instr(OP_TST, 3'd2, 3'd0, 3'd1, 5'd0, 32'd0));
      send_instr(make_instr(OP_TST, 3'd0, 3'd2, 3'd1, 5'd0, 32'd0));
      send_instr(make_instr(OP_LSR, 3'd5, 3'd0, 3'd0, 5'd0, 32'd0));
      send_instr(make_instr(OP_LSR, 3'd5, 3'd0, 3'd0, 5'd31, 32'd0));
      send_instr(make_instr(OP_LSL, 3'd6, 3'd0, 3'd0, 5'd31, 32'd0));
      send_instr(make_instr(OP_LSL, 3'd6, 3'd1, 3'd0, 5'd1, 32'd0));
      send_instr(make_instr(OP_LSL, 3'd7, 3'd2, 3'd0, 5'd0, 32'd0));
      send_instr(make_instr(OP_UNDEF_FIRST, 3'd0, 3'd0, 3'd0, 5'd0, 32'd0));
      send_instr(make_instr(OP_UNDEF_LAST, 3'd7, 3'd7, 3'd7, 5'd31, 32'hFFFF_FFFF));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         quiet = (i >= QUIET_FROM);
         send_instr(random_instr());
      end
      req_if.valid <= 1'b0;
      @(posedge clock);

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d instruction beats (%0d with undefined opcodes) and %0d result beats,",
               accepted_count, sb.undefined_seen, sb.checked);
      $display("including a %0d-cycle result hold-off; %0d mismatches, %0d results outstanding.",
               HOLD_CYCLES, sb.mismatches, sb.pending.size());
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
